[hw/rtl/pfe_pkg.sv]
// ============================================================================
// pfe_pkg
// Shared types, constants and the CRC15 byte update for the PEC frame engine.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package pfe_pkg;

  localparam logic [14:0] PEC_POLY  = 15'h4599;
  localparam logic [14:0] PEC_SEED  = 15'h0010;
  localparam int          QDEPTH    = 4;
  localparam int          MAX_ITEMS = 3;
  localparam int          PTR_W     = $clog2(QDEPTH);
  localparam int          CNT_W     = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       ok;
    logic       err;
  } pfe_item_t;

  typedef struct packed {
    logic [1:0]      count;
    pfe_item_t [2:0] item;
  } pfe_push_t;

  // One byte through the CRC15, MSB first.
  function automatic logic [14:0] pec_update(input logic [14:0] crc_in,
                                             input logic [7:0]  b);
    logic [14:0] c;
    c = crc_in ^ {b, 7'b0};
    for (int k = 0; k < 8; k++) begin
      if (c[14]) begin
        c = {c[13:0], 1'b0} ^ PEC_POLY;
      end else begin
        c = {c[13:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/pfe_core.sv]
// ============================================================================
// pfe_core
// Frame state (CRC, two-byte delay line, count) and result items per word.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module pfe_core
  import pfe_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  input  wire logic       in_mode,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_last,
  output pfe_push_t       push
);

  logic [14:0] crc;
  logic [14:0] crc_next;
  logic [7:0]  held0;
  logic [7:0]  held0_next;
  logic [7:0]  held1;
  logic [7:0]  held1_next;
  logic [1:0]  cnt;
  logic [1:0]  cnt_next;

  logic [7:0]  upd_byte;
  logic [14:0] crc_upd;
  logic [15:0] pec;

  assign upd_byte = in_mode ? held0 : in_byte;
  assign crc_upd  = pec_update(crc, upd_byte);
  assign pec      = {crc_upd, 1'b0};

  always_comb begin
    crc_next   = crc;
    held0_next = held0;
    held1_next = held1;
    cnt_next   = cnt;
    push       = '0;
    push.item[0].data = in_byte;
    if (in_valid) begin
      if (!in_mode) begin
        if (in_last) begin
          push.count        = 2'd3;
          push.item[1].data = pec[15:8];
          push.item[2].data = pec[7:0];
          push.item[2].last = 1'b1;
          crc_next          = PEC_SEED;
          held0_next        = '0;
          held1_next        = '0;
          cnt_next          = '0;
        end else begin
          push.count = 2'd1;
          crc_next   = crc_upd;
        end
      end else if (!in_last) begin
        push.count = 2'd1;
        if (cnt >= 2'd2) begin
          crc_next = crc_upd;
        end
        held0_next = held1;
        held1_next = in_byte;
        if (cnt != 2'd3) begin
          cnt_next = cnt + 2'd1;
        end
      end else begin
        push.count        = 2'd1;
        push.item[0].last = 1'b1;
        if (cnt < 2'd2) begin
          push.item[0].err = 1'b1;
        end else begin
          push.item[0].ok = (pec == {held1, in_byte});
        end
        crc_next   = PEC_SEED;
        held0_next = '0;
        held1_next = '0;
        cnt_next   = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc   <= PEC_SEED;
      held0 <= '0;
      held1 <= '0;
      cnt   <= '0;
    end else begin
      crc   <= crc_next;
      held0 <= held0_next;
      held1 <= held1_next;
      cnt   <= cnt_next;
    end
  end

  a_restart: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_last |=> crc == PEC_SEED && cnt == 2'd0)
    else $error("frame state not restarted after last word");

  a_flags_excl: assert property (@(posedge clk) disable iff (rst)
    !(push.item[0].ok && push.item[0].err))
    else $error("pec_ok and frame_error both set");

  a_three_ends: assert property (@(posedge clk) disable iff (rst)
    push.count == 2'd3 |-> push.item[2].last && !push.item[0].last && !in_mode)
    else $error("appended PEC words malformed");

  a_flags_check_only: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_mode |-> !push.item[0].ok && !push.item[0].err)
    else $error("flags raised in generate mode");

endmodule

`default_nettype wire

[hw/rtl/pfe_queue.sv]
// ============================================================================
// pfe_queue
// Four-entry result queue; takes up to three items per cycle, emits one when m_ready is high.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module pfe_queue
  import pfe_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  pfe_push_t  push,
  output logic       room,
  output logic       m_valid,
  input  wire logic  m_ready,
  output pfe_item_t  m_item
);

  pfe_item_t        q [QDEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             pop;

  assign m_valid = (count != '0);
  assign pop     = m_valid && m_ready;
  assign room    = (count <= CNT_W'(QDEPTH - MAX_ITEMS));
  assign m_item  = q[rd_ptr];

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_ITEMS; i++) begin
      if (2'(i) < push.count) begin
        q[wr_ptr + PTR_W'(i)] <= push.item[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_W'(push.count);
      rd_ptr <= rd_ptr + PTR_W'(pop);
      count  <= count + CNT_W'(push.count) - CNT_W'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push.count != 2'd0 |-> count <= CNT_W'(QDEPTH - MAX_ITEMS))
    else $error("push into full queue");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(QDEPTH))
    else $error("queue count out of range");

  a_ptr_track: assert property (@(posedge clk) disable iff (rst)
    count == '0 |-> wr_ptr == rd_ptr)
    else $error("pointers disagree on empty queue");

endmodule

`default_nettype wire

[hw/rtl/pec15_frame_engine_top.sv]
// ============================================================================
// pec15_frame_engine_top
// CRC15 (poly 0x4599, seed 16) PEC generate/check engine on a byte stream.
// ============================================================================
// Input stream s_*: one frame byte per word, s_tlast on the final byte,
// s_tuser = mode (0 generate, 1 check), applied per word.
// Output stream m_*: every input byte is echoed. In generate mode the last
// byte is followed by the PEC high and low bytes; m_tlast marks the low one.
// In check mode the echo of the last byte carries m_tlast and the flags
// pec_ok / frame_error in m_tuser.
// The echo is registered in the result queue before it appears on m_*.
// Throughput: one word per cycle while s_tready is high; the CRC byte
// update is combinational. A generate-mode last byte puts three words into
// the four-entry result queue, so input stalls until it drains to one word.
// s_tready is high while the queue holds at most one word, so a stalled
// receiver fills the queue and then holds off the input; nothing is dropped.
// Reset (rst, synchronous) empties the queue and reloads the seed; the frame
// state also restarts after each last byte.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module pec15_frame_engine_top
  import pfe_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_tvalid,
  output logic            s_tready,
  input  wire logic [7:0] s_tdata,   // [7:0] data_byte
  input  wire logic       s_tlast,
  input  wire logic       s_tuser,   // [0] mode
  output logic            m_tvalid,
  input  wire logic       m_tready,
  output logic [7:0]      m_tdata,   // [7:0] out_byte
  output logic            m_tlast,
  output logic [1:0]      m_tuser    // [0] pec_ok, [1] frame_error
);

  pfe_push_t push;
  pfe_item_t head;
  logic      room;

  assign s_tready = room;

  pfe_core u_core (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid && room),
    .in_mode  (s_tuser),
    .in_byte  (s_tdata),
    .in_last  (s_tlast),
    .push     (push)
  );

  pfe_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .room    (room),
    .m_valid (m_tvalid),
    .m_ready (m_tready),
    .m_item  (head)
  );

  assign m_tdata = head.data;
  assign m_tlast = head.last;
  assign m_tuser = {head.err, head.ok};

endmodule

`default_nettype wire

[test/tb_pec15_frame_engine_top.sv]
// ============================================================================
// tb_pec15_frame_engine_top
// Self-checking bench for the CRC15 PEC generate/check byte-stream engine.
// ============================================================================
// Frames go in on the s_* stream and every accepted word is run through a
// local PEC predictor that queues the words expected on m_*. A checker
// compares each accepted output word, field by field, with the oldest entry.
// The run has directed frames first: byte extremes, short and wrong-PEC check
// frames, and mode switches inside a frame. Random traffic follows in three
// idle phases. A long receiver hold-off then backs the engine up to its input.
// ============================================================================
`timescale 1ns / 1ps

module tb_pec15_frame_engine_top
  import pfe_pkg::*;
;

  localparam int STALL_CYCLES = 200;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = 8'h00;
  logic       s_tlast = 1'b0;
  logic       s_tuser = 1'b0;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;
  logic       m_tlast;
  logic [1:0] m_tuser;

  int src_idle_pct = 0;
  int sink_idle_pct = 0;
  logic sink_hold = 1'b0;
  int fail_cnt = 0;
  int words_sent = 0;

  // predictor state
  logic [14:0] pec_crc = PEC_SEED;
  logic [7:0]  pec_held [2] = '{8'h00, 8'h00};
  logic [1:0]  pec_cnt = 2'd0;
  pfe_item_t   out_word_q [$];

  pec15_frame_engine_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  always #4 clk = ~clk;

  // bit-serial form of the CRC15 byte update, MSB first
  function automatic logic [14:0] crc15_fold(input logic [14:0] crc, input logic [7:0] b);
    logic [14:0] r;
    logic fb;
    r = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = r[14] ^ b[i];
      r = {r[13:0], 1'b0} ^ (fb ? PEC_POLY : 15'h0000);
    end
    return r;
  endfunction

  function automatic logic [15:0] frame_pec(input logic [7:0] bytes [$]);
    logic [14:0] crc;
    crc = PEC_SEED;
    foreach (bytes[i]) crc = crc15_fold(crc, bytes[i]);
    return {crc, 1'b0};
  endfunction

  function automatic void push_word(logic [7:0] b, logic lst, logic ok, logic err);
    pfe_item_t w;
    w.data = b;
    w.last = lst;
    w.ok = ok;
    w.err = err;
    out_word_q.push_back(w);
  endfunction

  function automatic void clear_frame();
    pec_crc = PEC_SEED;
    pec_held[0] = 8'h00;
    pec_held[1] = 8'h00;
    pec_cnt = 2'd0;
  endfunction

  function automatic void pec_predict_word(logic md, logic [7:0] b, logic lst);
    logic [14:0] crc;
    logic [15:0] calc;
    logic [15:0] rx;
    if (!md) begin
      pec_crc = crc15_fold(pec_crc, b);
      push_word(b, 1'b0, 1'b0, 1'b0);
      if (lst) begin
        calc = {pec_crc, 1'b0};
        push_word(calc[15:8], 1'b0, 1'b0, 1'b0);
        push_word(calc[7:0], 1'b1, 1'b0, 1'b0);
        clear_frame();
      end
    end else if (!lst) begin
      if (pec_cnt >= 2'd2) pec_crc = crc15_fold(pec_crc, pec_held[0]);
      pec_held[0] = pec_held[1];
      pec_held[1] = b;
      if (pec_cnt != 2'd3) pec_cnt = pec_cnt + 2'd1;
      push_word(b, 1'b0, 1'b0, 1'b0);
    end else begin
      if (pec_cnt < 2'd2) begin
        push_word(b, 1'b1, 1'b0, 1'b1);
      end else begin
        crc = crc15_fold(pec_crc, pec_held[0]);
        calc = {crc, 1'b0};
        rx = {pec_held[1], b};
        push_word(b, 1'b1, calc == rx, 1'b0);
      end
      clear_frame();
    end
  endfunction

  task automatic send_word(input logic md, input logic [7:0] b, input logic lst);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    s_tlast <= lst;
    s_tuser <= md;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    words_sent++;
    pec_predict_word(md, b, lst);
  endtask

  task automatic send_frame(input logic md, input logic [7:0] bytes [$]);
    foreach (bytes[i]) send_word(md, bytes[i], i == bytes.size() - 1);
  endtask

  // receiver and output checker
  always @(posedge clk) begin : rx_check
    pfe_item_t exp_w;
    if (sink_hold) m_tready <= 1'b0;
    else m_tready <= ($urandom_range(99) >= sink_idle_pct);
    if (!rst && m_tvalid && m_tready) begin
      if (out_word_q.size() == 0) begin
        $error("unexpected word: out_byte %02h out_last %0b", m_tdata, m_tlast);
        fail_cnt++;
      end else begin
        exp_w = out_word_q.pop_front();
        if (m_tdata !== exp_w.data) begin
          $error("out_byte expected %02h actual %02h", exp_w.data, m_tdata);
          fail_cnt++;
        end
        if (m_tlast !== exp_w.last) begin
          $error("out_last expected %0b actual %0b", exp_w.last, m_tlast);
          fail_cnt++;
        end
        if (m_tuser[0] !== exp_w.ok) begin
          $error("pec_ok expected %0b actual %0b", exp_w.ok, m_tuser[0]);
          fail_cnt++;
        end
        if (m_tuser[1] !== exp_w.err) begin
          $error("frame_error expected %0b actual %0b", exp_w.err, m_tuser[1]);
          fail_cnt++;
        end
      end
    end
  end

  task automatic test_generate_directed();
    send_frame(1'b0, '{8'h00});
    send_frame(1'b0, '{8'hFF});
    send_frame(1'b0, '{8'hAA, 8'h55, 8'h0F});
  endtask

  task automatic test_check_directed();
    logic [15:0] pec;
    send_frame(1'b1, '{8'h81});
    send_frame(1'b1, '{8'h7E, 8'h01});
    pec = frame_pec('{8'h01});
    send_frame(1'b1, '{8'h01, pec[15:8], pec[7:0]});
    pec = frame_pec('{8'hFF, 8'h00}) ^ 16'h0100;
    send_frame(1'b1, '{8'hFF, 8'h00, pec[15:8], pec[7:0]});
  endtask

  task automatic test_mode_switch();
    send_word(1'b1, 8'h3C, 1'b0);
    send_word(1'b0, 8'hC3, 1'b0);
    send_word(1'b1, 8'h5A, 1'b0);
    send_word(1'b1, 8'hA5, 1'b1);
    send_word(1'b1, 8'h11, 1'b0);
    send_word(1'b0, 8'h22, 1'b1);
  endtask

  task automatic send_random_frame();
    logic [7:0] bytes [$];
    logic [15:0] pec;
    int kind;
    int len;
    kind = $urandom_range(99);
    len = ($urandom_range(9) == 0) ? $urandom_range(7, 16) : $urandom_range(1, 6);
    repeat (len) bytes.push_back(8'($urandom));
    if (kind < 45) begin
      pec = frame_pec(bytes);
      bytes.push_back(pec[15:8]);
      bytes.push_back(pec[7:0]);
      send_frame(1'b1, bytes);
    end else if (kind < 75) begin
      send_frame(1'b0, bytes);
    end else if (kind < 83) begin
      pec = frame_pec(bytes) ^ (16'h0001 << $urandom_range(15));
      bytes.push_back(pec[15:8]);
      bytes.push_back(pec[7:0]);
      send_frame(1'b1, bytes);
    end else if (kind < 91) begin
      bytes = bytes[0:$urandom_range(1) ? 0 : bytes.size() > 1 ? 1 : 0];
      send_frame(1'b1, bytes);
    end else begin
      foreach (bytes[i]) send_word(1'($urandom), bytes[i], i == bytes.size() - 1);
    end
  endtask

  task automatic test_random_traffic(input int n_words);
    int start_cnt;
    start_cnt = words_sent;
    while (words_sent - start_cnt < n_words) begin
      send_random_frame();
    end
  endtask

  task automatic test_backpressure();
    fork
      begin
        sink_hold <= 1'b1;
        repeat (STALL_CYCLES) @(posedge clk);
        sink_hold <= 1'b0;
      end
      test_random_traffic(30);
    join
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_generate_directed();
    test_check_directed();
    test_mode_switch();
    src_idle_pct <= 33;
    sink_idle_pct <= 84;
    test_random_traffic(115);
    src_idle_pct <= 84;
    sink_idle_pct <= 33;
    test_random_traffic(115);
    src_idle_pct <= 0;
    sink_idle_pct <= 0;
    test_random_traffic(115);
    test_backpressure();
    s_tvalid <= 1'b0;
    while (out_word_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
